// ===== src/rwr_pkg.sv =====
// Shared types, constants and the sequencer control store of the reorder window receiver.
package rwr_pkg;

  localparam int unsigned MAGIC_W    = 16;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned STEP_W     = 4;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_STORE   = 2'd1,
    KIND_DRAIN   = 2'd2,
    KIND_ACK     = 2'd3
  } rwr_kind_e;

  typedef struct packed {
    logic [MAGIC_W-1:0] magic;
    logic               checksum_ok;
    logic [SEQ_W-1:0]   sequence_req;
    logic [LEN_W-1:0]   payload_length;
    logic               end_of_file;
    logic [TIME_W-1:0]  timestamp;
  } rwr_in_t;

  typedef struct packed {
    rwr_kind_e             kind;
    logic [SEQ_W-1:0]      packet_sequence;
    logic [SLOT_OUT_W-1:0] slot;
    logic [LEN_W-1:0]      length;
    logic [SEQ_W-1:0]      ack_number;
    logic                  ack_eof;
    logic [TIME_W-1:0]     ack_time;
    logic                  last;
  } rwr_out_t;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NO_IN     = 3'd2,
    C_DROP      = 3'd3,
    C_MISS      = 3'd4,
    C_DRAIN_END = 3'd5,
    C_NO_STORE  = 3'd6
  } rwr_cond_e;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_FETCH = 4'd0;
  localparam step_t ST_CHECK = 4'd1;
  localparam step_t ST_MATCH = 4'd2;
  localparam step_t ST_DLV   = 4'd3;
  localparam step_t ST_PEEK  = 4'd4;
  localparam step_t ST_DRAIN = 4'd5;
  localparam step_t ST_WIN   = 4'd6;
  localparam step_t ST_TEST  = 4'd7;
  localparam step_t ST_STORE = 4'd8;
  localparam step_t ST_ACK   = 4'd9;

  typedef struct packed {
    logic      accept;    // take an input transfer
    logic      emit;      // load one result into the output register
    rwr_kind_e kind;
    logic      ne_inc;    // advance the expected sequence
    logic      clr_valid; // free the slot of the expected sequence
    logic      set_valid; // fill the slot computed for a packet ahead
    logic      ld_ahead;
    logic      ld_slot;
    logic      set_fin;   // latch finished when the packet carries eof
    logic      guard_clr;
    rwr_cond_e cond;
    step_t     target;
  } rwr_ctrl_t;

  // Control store: a condition that holds jumps to target, else fall through.
  function automatic rwr_ctrl_t rwr_rom(input step_t step);
    rwr_ctrl_t c;
    c = rwr_ctrl_t'('0);
    c.kind   = KIND_DELIVER;
    c.cond   = C_NEVER;
    c.target = ST_FETCH;
    unique case (step)
      ST_FETCH: begin
        c.accept = 1'b1;
        c.cond   = C_NO_IN;
        c.target = ST_FETCH;
      end
      ST_CHECK: begin
        c.cond   = C_DROP;
        c.target = ST_FETCH;
      end
      ST_MATCH: begin
        c.ld_ahead = 1'b1;
        c.cond     = C_MISS;
        c.target   = ST_WIN;
      end
      ST_DLV: begin
        c.emit      = 1'b1;
        c.kind      = KIND_DELIVER;
        c.ne_inc    = 1'b1;
        c.guard_clr = 1'b1;
      end
      ST_PEEK: begin
        c.cond   = C_DRAIN_END;
        c.target = ST_ACK;
      end
      ST_DRAIN: begin
        c.emit      = 1'b1;
        c.kind      = KIND_DRAIN;
        c.ne_inc    = 1'b1;
        c.clr_valid = 1'b1;
        c.cond      = C_ALWAYS;
        c.target    = ST_PEEK;
      end
      ST_WIN: begin
        c.ld_slot = 1'b1;
      end
      ST_TEST: begin
        c.cond   = C_NO_STORE;
        c.target = ST_ACK;
      end
      ST_STORE: begin
        c.emit      = 1'b1;
        c.kind      = KIND_STORE;
        c.set_valid = 1'b1;
      end
      ST_ACK: begin
        c.emit    = 1'b1;
        c.kind    = KIND_ACK;
        c.set_fin = 1'b1;
        c.cond    = C_ALWAYS;
        c.target  = ST_FETCH;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = ST_FETCH;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== src/rwr_in_if.sv =====
// Valid/ready channel carrying one arriving packet descriptor.
interface rwr_in_if import rwr_pkg::*; ();
  logic    valid;
  logic    ready;
  rwr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rwr_out_if.sv =====
// Valid/ready channel carrying one result item.
interface rwr_out_if import rwr_pkg::*; ();
  logic     valid;
  logic     ready;
  rwr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rwr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rwr_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/reorder_window_receiver.sv =====
// Reorder window receiver: selective-repeat receive side run by a microcoded sequencer.
// Steps: an in-order packet passes the check and match steps, then its delivery enters the
//   output register; one ahead of or outside the window adds the window and test steps.
// A descriptor is taken only in the fetch step, so the next waits until the last is done;
//   an in-order one then drains the buffered run; the peek/drain step pair that shares the
//   slot valid check and the single read port of the length RAM sets the per-slot cost.
// Reset (rst_ni low, asynchronous): expected sequence 1, all slot valid bits clear,
//   finished clear, magic register 0; no clearing pass, the length RAM is not reset.
module reorder_window_receiver import rwr_pkg::*; #(
  parameter int unsigned WINDOW_SLOTS = 16,
  parameter int unsigned MAX_PAYLOAD  = 1500
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MAGIC_W-1:0] cfg_wdata_i,
  rwr_in_if.sink             in_i,
  rwr_out_if.source          out_o
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SLOTS - 1);
  localparam logic [SLOT_W:0]   WIN_SUM   = (SLOT_W + 1)'(WINDOW_SLOTS);
  localparam logic [SEQ_W-1:0]  AHEAD_MAX = SEQ_W'(WINDOW_SLOTS - 1);
  localparam logic [SEQ_W-1:0]  WIN_SEQ   = SEQ_W'(WINDOW_SLOTS);
  localparam logic [SEQ_W-1:0]  SEQ_TOP   = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_PAYLOAD);

  // Sequencer
  step_t     step_q, step_d;
  rwr_ctrl_t ctrl;
  logic      in_xfer;
  logic      out_free;
  logic      fire;
  logic      cond_hit;

  // Control state
  logic [MAGIC_W-1:0]      cfg_magic_q;
  logic [SEQ_W-1:0]        ne_q;       // next expected sequence
  logic [SLOT_W-1:0]       ne_slot_q;  // next expected sequence mod window
  logic [WINDOW_SLOTS-1:0] valid_q;
  logic                    finished_q;
  logic                    out_valid_q;

  // Captured descriptor and scratch registers
  logic [MAGIC_W-1:0] magic_q;
  logic               csum_q;
  logic [SEQ_W-1:0]   seq_q;
  logic [LEN_W-1:0]   len_q;
  logic               eof_q;
  logic [TIME_W-1:0]  ts_q;
  logic [SEQ_W-1:0]   ahead_q;
  logic [SLOT_W-1:0]  s_q, s_d;
  logic               inwin_q, inwin_d;
  logic [SLOT_W-1:0]  guard_q;
  logic [SLOT_W:0]    slot_sum;
  logic [SLOT_W:0]    slot_wrap;
  rwr_out_t           out_q, emit_data;

  logic [LEN_W-1:0]   ram_rdata;
  logic               ram_we;
  logic [LEN_W-1:0]   len_sat;

  assign ctrl        = rwr_rom(step_q);
  assign in_i.ready  = ctrl.accept;
  assign in_xfer     = in_i.valid && in_i.ready;
  // The output register takes a new result when empty or drained this cycle.
  assign out_free    = !out_valid_q || out_o.ready;
  assign fire        = !ctrl.emit || out_free;
  assign ram_we      = fire && ctrl.set_valid;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Clamp oversized payloads to what the receive buffer holds.
  assign len_sat = (in_i.data.payload_length > LEN_MAX) ? LEN_MAX
                                                         : in_i.data.payload_length;

  always_comb begin
    case (ctrl.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_NO_IN:     cond_hit = !in_xfer;
      C_DROP:      cond_hit = finished_q || (magic_q != cfg_magic_q) || !csum_q;
      C_MISS:      cond_hit = (seq_q != ne_q);
      C_DRAIN_END: cond_hit = !valid_q[ne_slot_q] || (guard_q == SLOT_LAST);
      C_NO_STORE:  cond_hit = !inwin_q || valid_q[s_q];
      default:     cond_hit = 1'b1;
    endcase

    step_d = step_q;
    if (fire) begin
      step_d = cond_hit ? ctrl.target : step_t'(step_q + 1'b1);
    end
  end

  // Slot of a packet ahead: small sequences map to themselves (this also covers the
  // 32-bit wrap); otherwise add the distance to the expected slot, wrapping once.
  always_comb begin
    slot_sum  = {1'b0, ne_slot_q} + {1'b0, ahead_q[SLOT_W-1:0]};
    slot_wrap = (slot_sum >= WIN_SUM) ? slot_sum - WIN_SUM : slot_sum;
    s_d       = (seq_q < WIN_SEQ) ? seq_q[SLOT_W-1:0] : slot_wrap[SLOT_W-1:0];
    inwin_d   = (ahead_q != '0) && (ahead_q <= AHEAD_MAX);
  end

  // Assemble the result for the current emit step; unused fields stay zero.
  always_comb begin
    emit_data      = rwr_out_t'('0);
    emit_data.kind = ctrl.kind;
    case (ctrl.kind)
      KIND_DELIVER: begin
        emit_data.packet_sequence = seq_q;
        emit_data.length          = len_q;
      end
      KIND_STORE: begin
        emit_data.packet_sequence = seq_q;
        emit_data.slot            = SLOT_OUT_W'(s_q);
        emit_data.length          = len_q;
      end
      KIND_DRAIN: begin
        emit_data.packet_sequence = ne_q;
        emit_data.slot            = SLOT_OUT_W'(ne_slot_q);
        emit_data.length          = ram_rdata;
      end
      KIND_ACK: begin
        emit_data.ack_number = ne_q - 1'b1;
        emit_data.ack_eof    = eof_q;
        emit_data.ack_time   = ts_q;
        emit_data.last       = 1'b1;
      end
      default: ;
    endcase
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  // Control state: expected sequence, slot valid bits, finished flag, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_magic_q <= '0;
      ne_q        <= SEQ_W'(1);
      ne_slot_q   <= SLOT_W'(1);
      valid_q     <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_magic_q <= cfg_wdata_i;
      end
      if (fire && ctrl.ne_inc) begin
        ne_q <= ne_q + 1'b1;
        // Both counters wrap together at the top of the sequence space.
        if (ne_q == SEQ_TOP || ne_slot_q == SLOT_LAST) begin
          ne_slot_q <= '0;
        end else begin
          ne_slot_q <= ne_slot_q + 1'b1;
        end
      end
      if (fire && ctrl.clr_valid) begin
        valid_q[ne_slot_q] <= 1'b0;
      end
      if (fire && ctrl.set_valid) begin
        valid_q[s_q] <= 1'b1;
      end
      if (fire && ctrl.set_fin && eof_q) begin
        finished_q <= 1'b1;
      end
      if (fire && ctrl.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      magic_q <= in_i.data.magic;
      csum_q  <= in_i.data.checksum_ok;
      seq_q   <= in_i.data.sequence_req;
      len_q   <= len_sat;
      eof_q   <= in_i.data.end_of_file;
      ts_q    <= in_i.data.timestamp;
    end
    if (fire && ctrl.ld_ahead) begin
      ahead_q <= seq_q - ne_q;
    end
    if (fire && ctrl.ld_slot) begin
      s_q     <= s_d;
      inwin_q <= inwin_d;
    end
    if (fire && ctrl.guard_clr) begin
      guard_q <= '0;
    end else if (fire && ctrl.clr_valid) begin
      guard_q <= guard_q + 1'b1;
    end
    if (fire && ctrl.emit) begin
      out_q <= emit_data;
    end
  end

  // Buffered lengths; the read port always follows the expected slot.
  rwr_ram #(
    .WIDTH (LEN_W),
    .DEPTH (WINDOW_SLOTS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s_q),
    .wdata_i (len_q),
    .raddr_i (ne_slot_q),
    .rdata_o (ram_rdata)
  );

  // A drain only ever releases a slot that holds a packet.
  a_drain_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_DRAIN && fire) |-> valid_q[ne_slot_q])
    else $error("drain from an empty slot");

  // A store only ever fills an empty slot.
  a_store_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == ST_STORE && fire) |-> !valid_q[s_q])
    else $error("store into an occupied slot");

  // Once finished, no further result is produced.
  a_finished_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> !(fire && ctrl.emit))
    else $error("result after end of file");

  // The acknowledgment closes every result group.
  a_ack_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ctrl.emit) |=> (out_q.last == (out_q.kind == KIND_ACK)))
    else $error("last flag does not match acknowledgment");

endmodule

// ===== bench/reorder_window_receiver_tb.sv =====
// Self-checking testbench for the reorder window receiver: directed and random packet streams.
`timescale 1ns / 100ps

module reorder_window_receiver_tb import rwr_pkg::*; ();

  // Predicts the result stream of the receiver and checks every result transfer against it.
  class window_scoreboard;

    localparam int WINDOW  = 16;
    localparam int MAX_LEN = 1500;

    logic [MAGIC_W-1:0] magic;
    logic [SEQ_W-1:0]   next_seq;
    bit                 slot_full [WINDOW];
    logic [LEN_W-1:0]   slot_len [WINDOW];
    bit                 finished;

    rwr_out_t    pending_results [$];
    int unsigned errors;
    int unsigned n_transfers;
    int unsigned n_accepted;
    int unsigned n_results;
    int unsigned n_stores;
    int unsigned n_drains;

    function new();
      magic    = '0;
      next_seq = 1;
      finished = 0;
      foreach (slot_full[i]) slot_full[i] = 0;
    endfunction

    function rwr_out_t make_result(rwr_kind_e k, logic [SEQ_W-1:0] seq, logic [3:0] slot,
                                   logic [LEN_W-1:0] len, logic [SEQ_W-1:0] ack_num,
                                   logic eof, logic [TIME_W-1:0] ts, logic fin);
      rwr_out_t r;
      r.kind            = k;
      r.packet_sequence = seq;
      r.slot            = slot;
      r.length          = len;
      r.ack_number      = ack_num;
      r.ack_eof         = eof;
      r.ack_time        = ts;
      r.last            = fin;
      return r;
    endfunction

    // Print only the first mismatches to keep the log short; count them all.
    task report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Note one accepted descriptor and queue the results it must cause.
    function void note_packet(rwr_in_t p);
      logic [LEN_W-1:0] len;
      logic [SEQ_W-1:0] ahead;
      logic [3:0]       s;
      n_transfers++;
      if (finished || p.magic != magic || !p.checksum_ok) return;
      n_accepted++;
      len = (p.payload_length > MAX_LEN) ? LEN_W'(MAX_LEN) : p.payload_length;
      if (p.sequence_req == next_seq) begin
        pending_results.push_back(make_result(KIND_DELIVER, next_seq, 0, len, 0, 0, 0, 0));
        next_seq++;
        // Release the run of buffered packets that now follow in order.
        for (int g = 0; g < WINDOW - 1; g++) begin
          s = next_seq[3:0];
          if (!slot_full[s]) break;
          pending_results.push_back(make_result(KIND_DRAIN, next_seq, s, slot_len[s],
                                                0, 0, 0, 0));
          slot_full[s] = 0;
          next_seq++;
          n_drains++;
        end
      end else begin
        ahead = p.sequence_req - next_seq;
        s     = p.sequence_req[3:0];
        if (ahead >= 1 && ahead <= WINDOW - 1 && !slot_full[s]) begin
          slot_full[s] = 1;
          slot_len[s]  = len;
          pending_results.push_back(make_result(KIND_STORE, p.sequence_req, s, len,
                                                0, 0, 0, 0));
          n_stores++;
        end
      end
      pending_results.push_back(make_result(KIND_ACK, 0, 0, 0, next_seq - 1,
                                            p.end_of_file, p.timestamp, 1));
      if (p.end_of_file) finished = 1;
    endfunction

    // Compare one result transfer with the oldest expectation.
    task check_result(rwr_out_t r);
      rwr_out_t e;
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d seq %0d", r.kind,
                                  r.packet_sequence));
        return;
      end
      e = pending_results.pop_front();
      if (r.kind != e.kind)
        report_mismatch($sformatf("kind %0d, want %0d", r.kind, e.kind));
      if (r.packet_sequence != e.packet_sequence)
        report_mismatch($sformatf("packet_sequence %0d, want %0d", r.packet_sequence,
                                  e.packet_sequence));
      if (r.slot != e.slot)
        report_mismatch($sformatf("slot %0d, want %0d", r.slot, e.slot));
      if (r.length != e.length)
        report_mismatch($sformatf("length %0d, want %0d", r.length, e.length));
      if (r.ack_number != e.ack_number)
        report_mismatch($sformatf("ack_number %0d, want %0d", r.ack_number, e.ack_number));
      if (r.ack_eof != e.ack_eof)
        report_mismatch($sformatf("ack_eof %0d, want %0d", r.ack_eof, e.ack_eof));
      if (r.ack_time != e.ack_time)
        report_mismatch($sformatf("ack_time %h, want %h", r.ack_time, e.ack_time));
      if (r.last != e.last)
        report_mismatch($sformatf("last %0d, want %0d", r.last, e.last));
    endtask
  endclass

  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 12;    // covers the input-to-output latency and a drop
  localparam int WATCHDOG     = 4000;  // cycles without any transfer before giving up
  localparam int HOLD_AT      = 80;    // input transfers before the long output stall
  localparam int LONG_HOLD    = 90;    // length of that stall, in cycles

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [MAGIC_W-1:0] cfg_wdata_i;

  rwr_in_if  pkt_if ();
  rwr_out_if res_if ();

  reorder_window_receiver i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (pkt_if),
    .out_o       (res_if)
  );

  window_scoreboard tracker = new();

  int send_idle_pct = 32;
  int recv_idle_pct = 63;
  int good_sent;
  int hold_left;
  bit hold_done;
  int quiet_cycles;
  logic [MAGIC_W-1:0] mid_magic;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sample both channels at the rising edge; inputs were set up at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pkt_if.valid && pkt_if.ready) tracker.note_packet(pkt_if.data);
      if (res_if.valid && res_if.ready) tracker.check_result(res_if.data);
    end
  end

  // Result sink: random back-pressure, plus one long stall once enough input has gone in
  // so that the output fills up and the block must stop taking descriptors.
  always @(negedge clk_i) begin
    if (!hold_done && tracker.n_transfers >= HOLD_AT) begin
      hold_left = LONG_HOLD;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding", WATCHDOG,
               tracker.pending_results.size());
      $display("FAIL reorder_window_receiver");
      $finish;
    end
  end

  function automatic rwr_in_t make_packet(logic [MAGIC_W-1:0] mg, logic csum,
                                          logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] len,
                                          logic eof, logic [TIME_W-1:0] ts);
    rwr_in_t p;
    p.magic          = mg;
    p.checksum_ok    = csum;
    p.sequence_req   = seq;
    p.payload_length = len;
    p.end_of_file    = eof;
    p.timestamp      = ts;
    return p;
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    // Mostly legal sizes, some above the payload limit to hit saturation.
    if ($urandom_range(99) < 15) return LEN_W'($urandom_range(1501, 2047));
    return LEN_W'($urandom_range(0, 1500));
  endfunction

  // Offer one descriptor; call and return at a falling edge. The caller either offers
  // the next one right away or lowers valid, so an accepted item is never repeated.
  task automatic send_packet(rwr_in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pkt_if.valid <= 1'b1;
    pkt_if.data  <= p;
    do @(posedge clk_i); while (!pkt_if.ready);
    @(negedge clk_i);
  endtask

  // Stop offering, wait for every expected result, let the block go quiet, then
  // switch the idle mix for the next stretch.
  task automatic drain_and_settle(int next_send_pct, int next_recv_pct);
    pkt_if.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    send_idle_pct = next_send_pct;
    recv_idle_pct = next_recv_pct;
    @(negedge clk_i);
  endtask

  // Write the magic register while the block is idle.
  task automatic write_magic(logic [MAGIC_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.magic = value;
  endtask

  // Send one burst of n consecutive sequences from the expected one, in shuffled order,
  // with some corrupted descriptors, stray sequences and repeats mixed in.
  task automatic send_burst(int n);
    logic [SEQ_W-1:0] seqs [$];
    logic [SEQ_W-1:0] tmp;
    logic [SEQ_W-1:0] base;
    logic [MAGIC_W-1:0] bad_magic;
    int j;
    int r;
    base = tracker.next_seq;
    for (int i = 0; i < n; i++) seqs.push_back(base + i);
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = seqs[i];
      seqs[i] = seqs[j];
      seqs[j] = tmp;
    end
    foreach (seqs[i]) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // Corrupted header: wrong magic or failed checksum; any eof value is safe here.
        bad_magic = tracker.magic ^ MAGIC_W'($urandom_range(1, 16'hFFFF));
        if ($urandom_range(1))
          send_packet(make_packet(bad_magic, 1'($urandom_range(1)), $urandom, rand_len(),
                                  1'($urandom_range(1)), $urandom));
        else
          send_packet(make_packet(tracker.magic, 1'b0, seqs[i], rand_len(),
                                  1'($urandom_range(1)), $urandom));
      end else if (r < 13) begin
        // Stray sequence: behind the window, beyond it, or anywhere.
        case ($urandom_range(2))
          0:       tmp = tracker.next_seq - $urandom_range(1, 40);
          1:       tmp = tracker.next_seq + $urandom_range(16, 60);
          default: tmp = $urandom;
        endcase
        send_packet(make_packet(tracker.magic, 1'b1, tmp, rand_len(), 1'b0, $urandom));
        good_sent++;
      end else begin
        send_packet(make_packet(tracker.magic, 1'b1, seqs[i], rand_len(), 1'b0, $urandom));
        good_sent++;
        // Retransmission of the same sequence hits a full slot or falls behind.
        if (r < 18) begin
          send_packet(make_packet(tracker.magic, 1'b1, seqs[i], rand_len(), 1'b0,
                                  $urandom));
          good_sent++;
        end
      end
    end
  endtask

  task automatic run_random(int target);
    good_sent = 0;
    while (good_sent < target)
      send_burst(($urandom_range(99) < 70) ? $urandom_range(1, 5) : $urandom_range(6, 15));
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    pkt_if.valid = 1'b0;
    pkt_if.data  = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, magic still at its reset value of zero.
    send_packet(make_packet(16'h0000, 1'b1, 1, 0, 1'b0, 32'h0000_0000));    // in order
    send_packet(make_packet(16'h0000, 1'b0, 2, 100, 1'b0, 32'h1234_5678));  // bad checksum
    send_packet(make_packet(16'hFFFF, 1'b1, 2, 100, 1'b1, 32'h1234_5678));  // wrong magic
    send_packet(make_packet(16'h0000, 1'b1, 2, 2047, 1'b0, 32'hFFFF_FFFF)); // oversized
    send_packet(make_packet(16'h0000, 1'b1, 0, 10, 1'b0, $urandom));        // just behind
    send_packet(make_packet(16'h0000, 1'b1, 32'hFFFF_FFFF, 10, 1'b0, $urandom));
    send_packet(make_packet(16'h0000, 1'b1, 19, 10, 1'b0, $urandom));       // one past
    // Fill every slot ahead of the expected one from the far edge down, then repeat one slot.
    for (int k = 15; k >= 1; k--)
      send_packet(make_packet(16'h0000, 1'b1, 3 + k,
                              (k == 15) ? 11'd2047 : (k == 14) ? 11'd1501 :
                              (k == 13) ? 11'd1500 : LEN_W'($urandom_range(0, 1500)),
                              1'b0, $urandom));
    send_packet(make_packet(16'h0000, 1'b1, 10, 77, 1'b0, $urandom));       // slot taken
    send_packet(make_packet(16'h0000, 1'b1, 3, 5, 1'b0, $urandom));         // full drain

    drain_and_settle(32, 63);
    write_magic(16'hFFFF);
    run_random(30);

    drain_and_settle(63, 32);
    mid_magic = MAGIC_W'($urandom_range(1, 16'hFFFE));
    write_magic(mid_magic);
    run_random(30);

    drain_and_settle(0, 0);
    write_magic(16'h0000);
    run_random(13);
    // Pause the sender until everything has come out, then carry on.
    drain_and_settle(0, 0);
    run_random(13);

    // Last packet of the stream; afterwards even well-formed packets are ignored.
    send_packet(make_packet(tracker.magic, 1'b1, tracker.next_seq, rand_len(), 1'b1,
                            $urandom));
    for (int k = 0; k < 3; k++)
      send_packet(make_packet(tracker.magic, 1'b1, tracker.next_seq + k, rand_len(),
                              1'($urandom_range(1)), $urandom));
    drain_and_settle(0, 0);

    if (tracker.pending_results.size() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived",
                                        tracker.pending_results.size()));
    $display("Run covered %0d descriptors (%0d passing the header checks), %0d results",
             tracker.n_transfers, tracker.n_accepted, tracker.n_results);
    $display("  with %0d slot stores, %0d slot drains, magic 0/FFFF/%h/0, %0d mismatches",
             tracker.n_stores, tracker.n_drains, mid_magic, tracker.errors);
    if (tracker.errors == 0) begin
      $display("PASS reorder_window_receiver");
    end else begin
      $display("FAIL reorder_window_receiver");
    end
    $finish;
  end

endmodule
